### sv/lprm_pkg.sv
// Shared constants, codes and controller/datapath interface types for the LRU page manager.
`default_nettype none
package lprm_pkg;

  localparam int MAX_PAGES  = 16;
  localparam int STAMP_BITS = 32;
  localparam int PAGE_BITS  = $clog2(MAX_PAGES);
  localparam int CNT_BITS   = 5;
  localparam int CFG_BITS   = 5;
  localparam int IDX_BITS   = 2;
  localparam int IN_BITS    = 8;
  localparam int OUT_BITS   = 8;

  localparam logic [STAMP_BITS-1:0] STAMP_MASK = {STAMP_BITS{1'b1}};
  localparam logic [CNT_BITS-1:0]   COUNT_MAX  = {CNT_BITS{1'b1}};

  typedef enum logic [IDX_BITS-1:0] {
    REG_BLOCK_ENABLED = 2'd0,
    REG_PAGE_TOTAL    = 2'd1,
    REG_RES_CAP       = 2'd2
  } reg_index_t;

  typedef enum logic [2:0] {
    ST_HIT           = 3'd0,
    ST_LOADED        = 3'd1,
    ST_FAILED_NOW    = 3'd2,
    ST_FAILED_BEFORE = 3'd3,
    ST_REJECTED      = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_EVCHK,
    S_SCAN,
    S_FIN,
    S_LOAD,
    S_RESULT
  } state_t;

  typedef struct packed {
    logic    latch_in;
    logic    advance;
    logic    hit;
    logic    scan_init;
    logic    scan_step;
    logic    evict;
    logic    load;
    logic    status_we;
    status_t status_code;
    logic    result_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic rejected;
    logic failed_before;
    logic req_resident;
    logic need_evict;
    logic scan_last;
    logic found;
    logic fetch_ok;
    logic out_free;
  } ctrl_sts_t;

endpackage
`default_nettype wire

### sv/lprm_ctrl.sv
// Controller state machine sequencing check, victim scan, eviction, load and result beat.
`default_nettype none
module lprm_ctrl
  import lprm_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire ctrl_sts_t sts,
  output ctrl_cmd_t      cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next      = state;
    cmd             = '0;
    cmd.status_code = ST_HIT;
    in_ready        = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          state_next   = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.status_we = 1'b1;
        if (sts.rejected) begin
          cmd.status_code = ST_REJECTED;
          state_next      = S_RESULT;
        end else if (sts.failed_before) begin
          cmd.status_code = ST_FAILED_BEFORE;
          state_next      = S_RESULT;
        end else if (sts.req_resident) begin
          cmd.advance     = 1'b1;
          cmd.hit         = 1'b1;
          cmd.status_code = ST_HIT;
          state_next      = S_RESULT;
        end else begin
          cmd.advance   = 1'b1;
          cmd.status_we = 1'b0;
          state_next    = S_EVCHK;
        end
      end
      S_EVCHK: begin
        if (sts.need_evict) begin
          cmd.scan_init = 1'b1;
          state_next    = S_SCAN;
        end else begin
          state_next = S_LOAD;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_last) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (sts.found) begin
          cmd.evict  = 1'b1;
          state_next = S_EVCHK;
        end else begin
          state_next = S_LOAD;
        end
      end
      S_LOAD: begin
        cmd.load        = 1'b1;
        cmd.status_we   = 1'b1;
        cmd.status_code = sts.fetch_ok ? ST_LOADED : ST_FAILED_NOW;
        state_next      = S_RESULT;
      end
      S_RESULT: begin
        if (sts.out_free) begin
          cmd.result_load = 1'b1;
          state_next      = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

### sv/lprm_datapath.sv
// Datapath: config registers, page state, use serial, victim scan and output register.
`default_nettype none
module lprm_datapath
  import lprm_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_we,
  input  wire logic [IDX_BITS-1:0] cfg_index,
  input  wire logic [CFG_BITS-1:0] cfg_data,
  input  wire logic [PAGE_BITS-1:0] in_page,
  input  wire logic                in_fetch_ok,
  input  wire ctrl_cmd_t           cmd,
  output ctrl_sts_t                sts,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [2:0]               out_status,
  output logic                     out_evicted_valid,
  output logic [PAGE_BITS-1:0]     out_evicted_page
);

  logic                  block_enabled;
  logic [CNT_BITS-1:0]   page_total;
  logic [CNT_BITS-1:0]   res_cap;
  logic [MAX_PAGES-1:0]  resident;
  logic [MAX_PAGES-1:0]  failed;
  logic [STAMP_BITS-1:0] stamp [MAX_PAGES];
  logic [STAMP_BITS-1:0] serial;
  logic [CNT_BITS-1:0]   res_count;
  logic [PAGE_BITS-1:0]  req;
  logic                  ok;
  logic [PAGE_BITS-1:0]  idx;
  logic [STAMP_BITS-1:0] oldest;
  logic [PAGE_BITS-1:0]  victim;
  logic                  found;
  logic                  ev_valid;
  logic [PAGE_BITS-1:0]  ev_page;
  status_t               status;

  logic [CNT_BITS-1:0]   n;
  logic [STAMP_BITS-1:0] serial_inc;
  logic                  wrap;
  logic [STAMP_BITS-1:0] serial_adv;
  logic                  cand;

  assign n          = (page_total > CNT_BITS'(MAX_PAGES)) ? CNT_BITS'(MAX_PAGES) : page_total;
  assign serial_inc = (serial + STAMP_BITS'(1)) & STAMP_MASK;
  assign wrap       = (serial_inc == '0);
  assign serial_adv = wrap ? STAMP_BITS'(1) : serial_inc;
  assign cand       = (idx != req) && resident[idx] && (stamp[idx] <= oldest);

  always_comb begin
    sts.rejected      = !block_enabled || ({1'b0, req} >= n);
    sts.failed_before = failed[req];
    sts.req_resident  = resident[req];
    sts.need_evict    = (res_count >= res_cap);
    sts.scan_last     = ({1'b0, idx} == (n - CNT_BITS'(1)));
    sts.found         = found;
    sts.fetch_ok      = ok;
    sts.out_free      = !out_valid || out_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      block_enabled <= 1'b0;
      page_total    <= CNT_BITS'(1);
      res_cap       <= CNT_BITS'(2);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BLOCK_ENABLED: block_enabled <= cfg_data[0];
        REG_PAGE_TOTAL:    page_total    <= cfg_data;
        REG_RES_CAP:       res_cap       <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      resident  <= '0;
      failed    <= '0;
      serial    <= '0;
      res_count <= '0;
      for (int i = 0; i < MAX_PAGES; i++) begin
        stamp[i] <= '0;
      end
    end else begin
      if (cmd.advance) begin
        serial <= serial_adv;
        for (int i = 0; i < MAX_PAGES; i++) begin
          if (cmd.hit && (PAGE_BITS'(i) == req)) begin
            stamp[i] <= serial_adv;
          end else if (wrap && (CNT_BITS'(i) < n)) begin
            stamp[i] <= resident[i] ? STAMP_BITS'(1) : '0;
          end
        end
      end
      if (cmd.evict) begin
        resident[victim] <= 1'b0;
        stamp[victim]    <= '0;
        if (res_count != '0) begin
          res_count <= res_count - CNT_BITS'(1);
        end
      end
      if (cmd.load) begin
        if (ok) begin
          resident[req] <= 1'b1;
          stamp[req]    <= serial;
          if (res_count != COUNT_MAX) begin
            res_count <= res_count + CNT_BITS'(1);
          end
        end else begin
          failed[req] <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      req      <= in_page;
      ok       <= in_fetch_ok;
      ev_valid <= 1'b0;
      ev_page  <= '0;
    end
    if (cmd.scan_init) begin
      idx    <= '0;
      oldest <= STAMP_MASK;
      found  <= 1'b0;
    end
    if (cmd.scan_step) begin
      idx <= idx + PAGE_BITS'(1);
      if (cand) begin
        oldest <= stamp[idx];
        victim <= idx;
        found  <= 1'b1;
      end
    end
    if (cmd.evict) begin
      ev_valid <= 1'b1;
      ev_page  <= victim;
    end
    if (cmd.status_we) begin
      status <= cmd.status_code;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.result_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.result_load) begin
      out_status        <= status;
      out_evicted_valid <= ev_valid;
      out_evicted_page  <= ev_page;
    end
  end

endmodule
`default_nettype wire

### sv/lru_page_residency_manager_top.sv
// Top level of the LRU page residency manager: stream ports, config port, controller and datapath.
//
// Usage:
//   s_axis carries one page request per beat; m_axis returns one result beat per request.
//   cfg writes registers 0 block enable, 1 page total, 2 resident cap; cfg_ready is
//   always high. Write configuration only while no request is in flight.
// Sequence (accept to result valid):
//   rejected, failed-earlier or hit: check state, then result state.
//   miss without eviction: check, eviction check, load, then result state.
//   each eviction adds a victim scan over n = min(page total, 16) pages that reads one page
//   stamp per cycle, a finish state and an eviction check; a failed final scan adds scan and finish.
//   A new request is accepted in the cycle after its result is placed in the output register,
//   so items are processed one at a time.
// Reset: registers return to enabled 0, page total 1, resident cap 2; all pages
//   are non-resident, unfailed, stamps and use serial zero.
// Stall: the result waits in the output register while m_axis_tready is low; the next
//   request is accepted and processed meanwhile, and its result waits until the register frees.
`default_nettype none
module lru_page_residency_manager_top
  import lprm_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  input  wire logic [IN_BITS-1:0]  s_axis_tdata,   // [3:0] page, [4] fetch_ok
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  output logic [OUT_BITS-1:0]      m_axis_tdata,   // [2:0] status, [3] evicted_valid, [7:4] evicted_page
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [IDX_BITS-1:0] cfg_index,
  input  wire logic [CFG_BITS-1:0] cfg_data
);

  ctrl_cmd_t            cmd;
  ctrl_sts_t            sts;
  logic [2:0]           out_status;
  logic                 out_evicted_valid;
  logic [PAGE_BITS-1:0] out_evicted_page;

  assign cfg_ready    = 1'b1;
  assign m_axis_tdata = {out_evicted_page, out_evicted_valid, out_status};

  lprm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  lprm_datapath u_dp (
    .clk               (clk),
    .rst               (rst),
    .cfg_we            (cfg_valid & cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_page           (s_axis_tdata[PAGE_BITS-1:0]),
    .in_fetch_ok       (s_axis_tdata[PAGE_BITS]),
    .cmd               (cmd),
    .sts               (sts),
    .out_valid         (m_axis_tvalid),
    .out_ready         (m_axis_tready),
    .out_status        (out_status),
    .out_evicted_valid (out_evicted_valid),
    .out_evicted_page  (out_evicted_page)
  );

endmodule
`default_nettype wire

### sv/lprm_checker.sv
// Port-level assertions for the LRU page residency manager and their bind.
`default_nettype none
module lprm_checker
  import lprm_pkg::*;
(
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                s_axis_tvalid,
  input wire logic                s_axis_tready,
  input wire logic                m_axis_tvalid,
  input wire logic                m_axis_tready,
  input wire logic [OUT_BITS-1:0] m_axis_tdata
);

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[2:0] == ST_HIT || m_axis_tdata[2:0] == ST_LOADED ||
                       m_axis_tdata[2:0] == ST_FAILED_NOW ||
                       m_axis_tdata[2:0] == ST_FAILED_BEFORE ||
                       m_axis_tdata[2:0] == ST_REJECTED))
    else $error("status code out of range");

  a_evict_on_miss: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tdata[3]) |->
      (m_axis_tdata[2:0] == ST_LOADED || m_axis_tdata[2:0] == ST_FAILED_NOW))
    else $error("eviction reported on a request that was not a miss");

  a_no_evict_page_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tdata[3]) |-> (m_axis_tdata[7:4] == '0))
    else $error("evicted page nonzero without eviction");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("request accepted while another is in progress");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("result beat changed while stalled");

endmodule

bind lru_page_residency_manager_top lprm_checker u_lprm_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire
